// ===== sv/lfbc_pkg.sv =====
// Shared types and codes for the LED flash and blink controller.
package lfbc_pkg;

  localparam int NUM_LEDS_DEF    = 8;
  localparam int PERIOD_BITS_DEF = 16;
  localparam int REG_W           = 8;
  localparam int FIELD_PER_W     = 16;

  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_EXPIRY  = 2'd2;

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_ON    = 2'd1;
  localparam logic [1:0] MODE_FLASH = 2'd2;
  localparam logic [1:0] MODE_BLINK = 2'd3;

  localparam logic REG_ACTIVE_HIGH = 1'b0;
  localparam logic REG_LED_ENABLE  = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  led_index;
    logic [1:0]  new_state;
    logic [15:0] blink_period;
  } lfbc_in_t;

  typedef struct packed {
    logic [7:0] pin_levels;
    logic       restart_pulse;
  } lfbc_out_t;

  typedef struct packed {
    logic       req;
    logic       tick;
    logic       expire;
    logic [1:0] req_state;
  } lfbc_ctl_t;

endpackage

// ===== sv/lfbc_cell.sv =====
// State and next-state logic of a single LED.
module lfbc_cell import lfbc_pkg::*; #(
  parameter int PeriodBits = PERIOD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lfbc_ctl_t             ctl_i,
  input  logic [PeriodBits-1:0] period_i,
  output logic                  lit_d_o,
  output logic                  pulse_o
);

  logic [1:0]            cur_mode_q, cur_mode_d;
  logic [1:0]            want_mode_q, want_mode_d;
  logic [PeriodBits-1:0] cur_per_q, cur_per_d;
  logic [PeriodBits-1:0] want_per_q, want_per_d;
  logic [PeriodBits-1:0] count_q, count_d;
  logic                  pending_q, pending_d;
  logic                  lit_q, lit_d;
  logic                  pulse;

  always_comb begin
    cur_mode_d  = cur_mode_q;
    want_mode_d = want_mode_q;
    cur_per_d   = cur_per_q;
    want_per_d  = want_per_q;
    count_d     = count_q;
    pending_d   = pending_q;
    lit_d       = lit_q;
    pulse       = 1'b0;
    if (ctl_i.req) begin
      want_mode_d = ctl_i.req_state;
      if (ctl_i.req_state == MODE_BLINK) begin
        want_per_d = period_i;
      end
    end
    if (ctl_i.tick) begin
      if (cur_mode_q != want_mode_q) begin
        cur_mode_d = want_mode_q;
        case (want_mode_q)
          MODE_ON: begin
            lit_d = 1'b1;
          end
          MODE_OFF: begin
            lit_d = 1'b0;
          end
          MODE_FLASH: begin
            pulse       = 1'b1;
            want_mode_d = MODE_OFF;
            cur_mode_d  = MODE_OFF;
          end
          default: begin
            pulse     = 1'b1;
            cur_per_d = want_per_q;
            count_d   = want_per_q;
          end
        endcase
      end else if (cur_mode_q == MODE_BLINK) begin
        if (cur_per_q != want_per_q) begin
          cur_per_d = want_per_q;
          count_d   = want_per_q;
          pulse     = 1'b1;
        end else if (count_q != '0) begin
          count_d = count_q - PeriodBits'(1);
        end else begin
          pulse   = 1'b1;
          count_d = cur_per_q;
        end
      end
      if (pulse) begin
        lit_d     = 1'b1;
        pending_d = 1'b1;
      end
    end
    if (ctl_i.expire && pending_q) begin
      pending_d = 1'b0;
      lit_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_mode_q  <= MODE_OFF;
      want_mode_q <= MODE_OFF;
      cur_per_q   <= '0;
      want_per_q  <= '0;
      count_q     <= '0;
      pending_q   <= 1'b0;
      lit_q       <= 1'b0;
    end else begin
      cur_mode_q  <= cur_mode_d;
      want_mode_q <= want_mode_d;
      cur_per_q   <= cur_per_d;
      want_per_q  <= want_per_d;
      count_q     <= count_d;
      pending_q   <= pending_d;
      lit_q       <= lit_d;
    end
  end

  assign lit_d_o = lit_d;
  assign pulse_o = pulse;

endmodule

// ===== sv/led_flash_blink_controller_core.sv =====
// Top level of the LED flash and blink controller: registers, LED cells and result stage.
// One transaction is taken per clock cycle while in_ready_o is high. A transaction is held in
// an input register and, in the cycle in which it moves on, all LED cells update in parallel
// and the pin levels and restart flag are captured in the result register. in_ready_o is high
// when the input register is empty or moves on in that cycle, which it does unless a result is
// waiting and out_ready_i is low. Configuration writes take effect at once and are meant to be
// made only while the block is idle.
module led_flash_blink_controller_core import lfbc_pkg::*; #(
  parameter int NUM_LEDS    = NUM_LEDS_DEF,
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lfbc_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lfbc_out_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [REG_W-1:0] cfg_data_i
);

  logic [REG_W-1:0]       active_high_q;
  logic [REG_W-1:0]       enable_q;
  logic                   in_vld_q;
  lfbc_in_t               in_q;
  logic                   out_vld_q;
  lfbc_out_t              out_q;
  logic                   advance;
  logic [PERIOD_BITS-1:0] period;
  logic [NUM_LEDS-1:0]    lit_d;
  logic [NUM_LEDS-1:0]    pulse;
  logic [7:0]             pins;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  if (PERIOD_BITS > FIELD_PER_W) begin : g_per_wide
    assign period = {{(PERIOD_BITS - FIELD_PER_W){1'b0}}, in_q.blink_period};
  end else begin : g_per_narrow
    assign period = in_q.blink_period[PERIOD_BITS-1:0];
  end

  for (genvar i = 0; i < NUM_LEDS; i++) begin : g_led
    lfbc_ctl_t ctl;
    if (i < REG_W) begin : g_live
      assign ctl.req    = advance && (in_q.mode == KIND_REQUEST) && (in_q.led_index == 3'(i));
      assign ctl.tick   = advance && (in_q.mode == KIND_TICK) && enable_q[i];
    end else begin : g_idle
      assign ctl.req    = 1'b0;
      assign ctl.tick   = 1'b0;
    end
    assign ctl.expire    = advance && (in_q.mode == KIND_EXPIRY);
    assign ctl.req_state = in_q.new_state;

    lfbc_cell #(
      .PeriodBits(PERIOD_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .period_i(period),
      .lit_d_o (lit_d[i]),
      .pulse_o (pulse[i])
    );
  end

  for (genvar b = 0; b < 8; b++) begin : g_pin
    if (b < NUM_LEDS) begin : g_used
      assign pins[b] = ~(lit_d[b] ^ active_high_q[b]);
    end else begin : g_unused
      assign pins[b] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_high_q <= '0;
      enable_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ACTIVE_HIGH: active_high_q <= cfg_data_i;
        REG_LED_ENABLE:  enable_q      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q.pin_levels    <= pins;
      out_q.restart_pulse <= |pulse;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
